// ===== src/psf2_unicode_table_mapper_defines.svh =====
// assertion macros shared by the psf2 unicode table mapper rtl
// no dependencies; modules that assert include this file by name
`ifndef PSF2_UNICODE_TABLE_MAPPER_DEFINES_SVH
`define PSF2_UNICODE_TABLE_MAPPER_DEFINES_SVH

// concurrent property check, held off while reset is asserted
`define PSF2_UTM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("psf2 mapper check failed");

// property check that also holds during reset
`define PSF2_UTM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("psf2 mapper check failed");

`endif

// ===== src/psf2_utm_pkg.sv =====
// shared types and constants for the psf2 unicode table mapper
// no dependencies
package psf2_utm_pkg;

    localparam int BYTE_W        = 8;
    localparam int GLYPH_BYTES_W = 16;
    localparam int CODE_W        = 21;
    localparam int GLYPH_NUM_W   = 16;
    localparam int GLYPH_OFF_W   = 32;
    localparam int KIND_W        = 3;

    localparam int OFFSET_BITS_DEF = 32;

    // result payload rounded up to whole bytes
    localparam int M_TDATA_W = ((CODE_W + GLYPH_NUM_W + GLYPH_OFF_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - (CODE_W + GLYPH_NUM_W + GLYPH_OFF_W);

    localparam logic [GLYPH_BYTES_W-1:0] GLYPH_BYTES_RESET = 16'd16;

    localparam logic [BYTE_W-1:0] SEQ_START = 8'hFE;
    localparam logic [BYTE_W-1:0] SEPARATOR = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_ABSORB  = 3'd0,
        KIND_MAP     = 3'd1,
        KIND_BAD_UTF = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] table_byte;
        logic              first;
    } item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CODE_W-1:0]      code_point;
        logic [GLYPH_NUM_W-1:0] glyph_number;
        logic [GLYPH_OFF_W-1:0] glyph_offset;
    } result_t;

endpackage

// ===== src/psf2_utm_in_reg.sv =====
// input register of the psf2 unicode table mapper
// depends on psf2_utm_pkg
module psf2_utm_in_reg
    import psf2_utm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== src/psf2_utm_core.sv =====
// parse state and per-byte decode of the psf2 unicode table mapper
// depends on psf2_utm_pkg and the shared assertion macros
`include "psf2_unicode_table_mapper_defines.svh"
module psf2_utm_core
    import psf2_utm_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [GLYPH_BYTES_W-1:0] cfg_wdata,
    input  logic                     fire,
    input  item_t                    item,
    output result_t                  res
);

    logic [GLYPH_BYTES_W-1:0] gbytes_reg;
    logic [GLYPH_NUM_W-1:0]   gcnt_reg, gcnt, gcnt_next;
    logic [OFFSET_BITS-1:0]   off_reg, off, off_next;
    logic [CODE_W-1:0]        pc_reg, pc, pc_next;
    logic [1:0]               held_reg, held, held_next;
    logic [2:0]               exp_reg, expl, exp_next;
    logic                     stop_reg, stop, stop_next;

    logic [BYTE_W-1:0]      b;
    logic [CODE_W-1:0]      cp_cat;
    logic [2:0]             held_inc;
    logic [2:0]             len;
    logic [OFFSET_BITS:0]   sum;

    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] v);
        logic [2:0] n;
        if (!v[7]) begin
            n = 3'd1;
        end else if (v[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (v[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (v[7:3] == 5'b11110) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic logic [6:0] lead_bits(input logic [BYTE_W-1:0] v,
                                             input logic [2:0] n);
        logic [6:0] r;
        case (n)
            3'd2:    r = {2'b00, v[4:0]};
            3'd3:    r = {3'b000, v[3:0]};
            3'd4:    r = {4'b0000, v[2:0]};
            default: r = v[6:0];
        endcase
        return r;
    endfunction

    // rejects overlong forms, surrogates and values past the unicode range
    function automatic logic code_ok(input logic [CODE_W-1:0] cp, input logic [2:0] n);
        logic ok;
        case (n)
            3'd2:    ok = (cp >= 21'h80);
            3'd3:    ok = (cp >= 21'h800) && ((cp < 21'hD800) || (cp > 21'hDFFF));
            3'd4:    ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    always_comb begin
        // first beat of a table starts from a clean state
        gcnt = item.first ? '0 : gcnt_reg;
        off  = item.first ? '0 : off_reg;
        pc   = item.first ? '0 : pc_reg;
        held = item.first ? '0 : held_reg;
        expl = item.first ? '0 : exp_reg;
        stop = item.first ? 1'b0 : stop_reg;

        b        = item.table_byte;
        cp_cat   = {pc[CODE_W-7:0], b[5:0]};
        held_inc = {1'b0, held} + 3'd1;
        len      = lead_length(b);
        sum      = {1'b0, off} + (OFFSET_BITS+1)'(gbytes_reg);

        gcnt_next = gcnt;
        off_next  = off;
        pc_next   = pc;
        held_next = held;
        exp_next  = expl;
        stop_next = stop;

        res.kind       = KIND_ABSORB;
        res.code_point = '0;

        if (stop) begin
            res.kind = KIND_IGNORED;
        end else if (b == SEQ_START) begin
            stop_next = 1'b1;
            pc_next   = '0;
            held_next = '0;
            exp_next  = '0;
            res.kind  = KIND_STOP;
        end else if (b == SEPARATOR) begin
            // a separator that cuts a sequence short still advances the glyph
            if (held != 2'd0) begin
                res.kind = KIND_BAD_UTF;
            end
            pc_next   = '0;
            held_next = '0;
            exp_next  = '0;
            gcnt_next = (gcnt == '1) ? gcnt : gcnt + 16'd1;
            off_next  = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
        end else if (held == 2'd0) begin
            case (len)
                3'd0: begin
                    res.kind = KIND_BAD_UTF;
                end
                3'd1: begin
                    res.kind       = KIND_MAP;
                    res.code_point = CODE_W'(b);
                end
                default: begin
                    pc_next   = CODE_W'(lead_bits(b, len));
                    held_next = 2'd1;
                    exp_next  = len;
                end
            endcase
        end else if (b[7:6] != 2'b10) begin
            res.kind  = KIND_BAD_UTF;
            pc_next   = '0;
            held_next = '0;
            exp_next  = '0;
        end else if (held_inc >= expl) begin
            if (code_ok(cp_cat, expl)) begin
                res.kind       = KIND_MAP;
                res.code_point = cp_cat;
            end else begin
                res.kind = KIND_BAD_UTF;
            end
            pc_next   = '0;
            held_next = '0;
            exp_next  = '0;
        end else begin
            pc_next   = cp_cat;
            held_next = held_inc[1:0];
        end

        res.glyph_number = gcnt_next;
        res.glyph_offset = GLYPH_OFF_W'(off_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gbytes_reg <= GLYPH_BYTES_RESET;
            gcnt_reg   <= '0;
            off_reg    <= '0;
            pc_reg     <= '0;
            held_reg   <= '0;
            exp_reg    <= '0;
            stop_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                gbytes_reg <= cfg_wdata;
            end
            if (fire) begin
                gcnt_reg <= gcnt_next;
                off_reg  <= off_next;
                pc_reg   <= pc_next;
                held_reg <= held_next;
                exp_reg  <= exp_next;
                stop_reg <= stop_next;
            end
        end
    end

    // a partial sequence always has fewer bytes than its lead promised
    `PSF2_UTM_ASSERT(a_held_below_len, (held_reg == 2'd0) || ({1'b0, held_reg} < exp_reg))
    // the stop state never keeps a partial sequence
    `PSF2_UTM_ASSERT(a_stop_clears, !stop_reg || (held_reg == 2'd0))
    // glyph index only moves backward on a first beat
    `PSF2_UTM_ASSERT(a_gcnt_mono, (fire && !item.first) |=> (gcnt_reg >= $past(gcnt_reg)))

endmodule

// ===== src/psf2_utm_out_reg.sv =====
// result register of the psf2 unicode table mapper
// depends on psf2_utm_pkg and the shared assertion macros
`include "psf2_unicode_table_mapper_defines.svh"
module psf2_utm_out_reg
    import psf2_utm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = free ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    // code point is only nonzero on a mapping result
    `PSF2_UTM_ASSERT(a_cp_only_map, !valid_reg || (res_reg.kind == KIND_MAP) || (res_reg.code_point == '0))

endmodule

// ===== src/psf2_unicode_table_mapper.sv =====
// top level of the psf2 unicode table mapper: input register, decode, result register
// depends on psf2_utm_pkg, psf2_utm_in_reg, psf2_utm_core, psf2_utm_out_reg
//
//   channel   direction  beat contents
//   s_*       in         tdata: table_byte; tuser: first
//   m_*       out        tdata: code_point, glyph_number, glyph_offset; tuser: kind
//   cfg_*     in         glyph_bytes write, no read-back
//
// every byte gives exactly one result beat, via the input register and result register
// one beat per cycle while m_tready is high; index/offset next state is combinational
// aresetn is synchronous active low; glyph_bytes resets to 16, all parse state to zero
// a stalled m_ side holds one result and one byte in the input register, then s_tready drops
`include "psf2_unicode_table_mapper_defines.svh"
module psf2_unicode_table_mapper
    import psf2_utm_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input byte stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [BYTE_W-1:0]        s_tdata,   // [7:0] table_byte
    input  logic                     s_tuser,   // [0] first
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // [20:0] code_point, [36:21] glyph_number,
                                                // [68:37] glyph_offset, rest zero
    output logic [KIND_W-1:0]        m_tuser,   // [2:0] kind
    // glyph size register
    input  logic                     cfg_we,
    input  logic [GLYPH_BYTES_W-1:0] cfg_wdata
);

    item_t   s_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_free;
    logic    fire;
    result_t core_res;
    result_t out_res;

    assign s_item.table_byte = s_tdata;
    assign s_item.first      = s_tuser;

    // a held byte moves on whenever the result register can take it
    assign fire = held_valid && out_free;

    psf2_utm_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    psf2_utm_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (held_item),
        .res       (core_res)
    );

    psf2_utm_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .res_in    (core_res),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (out_res)
    );

    // pack result fields, lowest field first
    assign m_tdata = {{M_PAD_W{1'b0}}, out_res.glyph_offset,
                      out_res.glyph_number, out_res.code_point};
    assign m_tuser = out_res.kind;

    // back-pressure on the input only comes from a stalled full output
    `PSF2_UTM_ASSERT(a_stall_source, !s_tready |-> (m_tvalid && !m_tready))
    // nothing is shown on the result side during reset
    `PSF2_UTM_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid)

endmodule
